// ----- src/cat_pkg.sv -----
// Shared types and constants for the command line argument tokenizer.
// No dependencies; every other file refers to this package by scoped names.
package cat_pkg;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [2:0] {
        K_KEY       = 3'd0,
        K_VAL       = 3'd1,
        K_END_VAL   = 3'd2,
        K_END_NOVAL = 3'd3,
        K_DISCARD   = 3'd4
    } t_kind;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      out_kind;
        logic       run_last;
    } t_result;

    // One decoded input byte: zero, one or two results for the result queue.
    typedef struct packed {
        logic    valid;
        logic    two;
        t_result r0;
        t_result r1;
    } t_push;

endpackage

// ----- src/cat_if.sv -----
// Valid/ready channel interfaces for the tokenizer's input and result beats.
// Depends on cat_pkg for the result kind type.
interface cat_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] cmd_byte;

    modport source (output valid, output cmd_byte, input ready);
    modport sink   (input valid, input cmd_byte, output ready);
endinterface

interface cat_out_if;
    logic           valid;
    logic           ready;
    logic [7:0]     out_byte;
    cat_pkg::t_kind out_kind;
    logic           run_last;

    modport source (output valid, output out_byte, output out_kind, output run_last,
                    input ready);
    modport sink   (input valid, input out_byte, input out_kind, input run_last,
                    output ready);
endinterface

// ----- src/cat_dec.sv -----
// Input register, parse phase register and the per-byte decode logic.
// Depends on cat_pkg and cat_in_if.
module cat_dec (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cat_in_if.sink          i_cmd,
    input  logic            i_room,
    output cat_pkg::t_push  o_push
);

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_KEY      = 3'd1,
        PH_VSTART   = 3'd2,
        PH_UNQUOTED = 3'd3,
        PH_QUOTED   = 3'd4,
        PH_ESCAPE   = 3'd5
    } t_phase;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_phase     r_phase;
    t_phase     n_phase;

    logic           advance;
    logic [1:0]     n_count;
    logic [7:0]     b0;
    logic [7:0]     b1;
    cat_pkg::t_kind k0;
    cat_pkg::t_kind k1;

    assign i_cmd.ready = !r_in_valid || i_room;
    assign advance     = r_in_valid && i_room;

    always_comb begin
        n_phase = r_phase;
        n_count = 2'd0;
        b0      = cat_pkg::CH_NUL;
        b1      = cat_pkg::CH_NUL;
        k0      = cat_pkg::K_KEY;
        k1      = cat_pkg::K_VAL;
        case (r_phase)
            PH_KEY: begin
                if (r_in_byte inside {cat_pkg::CH_NUL, cat_pkg::CH_SPACE}) begin
                    n_count = 2'd1;
                    k0      = cat_pkg::K_END_NOVAL;
                    n_phase = PH_IDLE;
                end else if (r_in_byte == cat_pkg::CH_EQUAL) begin
                    n_phase = PH_VSTART;
                end else begin
                    n_count = 2'd1;
                    b0      = r_in_byte;
                    k0      = cat_pkg::K_KEY;
                end
            end
            PH_VSTART: begin
                if (r_in_byte inside {cat_pkg::CH_NUL, cat_pkg::CH_SPACE}) begin
                    n_count = 2'd1;
                    k0      = cat_pkg::K_END_VAL;
                    n_phase = PH_IDLE;
                end else if (r_in_byte == cat_pkg::CH_QUOTE) begin
                    n_phase = PH_QUOTED;
                end else begin
                    n_count = 2'd1;
                    b0      = r_in_byte;
                    k0      = cat_pkg::K_VAL;
                    n_phase = PH_UNQUOTED;
                end
            end
            PH_UNQUOTED: begin
                n_count = 2'd1;
                if (r_in_byte inside {cat_pkg::CH_NUL, cat_pkg::CH_SPACE}) begin
                    k0      = cat_pkg::K_END_VAL;
                    n_phase = PH_IDLE;
                end else begin
                    b0 = r_in_byte;
                    k0 = cat_pkg::K_VAL;
                end
            end
            PH_QUOTED: begin
                if (r_in_byte == cat_pkg::CH_NUL) begin
                    n_count = 2'd1;
                    k0      = cat_pkg::K_DISCARD;
                    n_phase = PH_IDLE;
                end else if (r_in_byte == cat_pkg::CH_QUOTE) begin
                    n_count = 2'd1;
                    k0      = cat_pkg::K_END_VAL;
                    n_phase = PH_IDLE;
                end else if (r_in_byte == cat_pkg::CH_BSLASH) begin
                    n_phase = PH_ESCAPE;
                end else begin
                    n_count = 2'd1;
                    b0      = r_in_byte;
                    k0      = cat_pkg::K_VAL;
                end
            end
            PH_ESCAPE: begin
                if (r_in_byte == cat_pkg::CH_NUL) begin
                    n_count = 2'd1;
                    k0      = cat_pkg::K_DISCARD;
                    n_phase = PH_IDLE;
                end else if (r_in_byte inside {cat_pkg::CH_QUOTE, cat_pkg::CH_BSLASH}) begin
                    n_count = 2'd1;
                    b0      = r_in_byte;
                    k0      = cat_pkg::K_VAL;
                    n_phase = PH_QUOTED;
                end else begin
                    // unknown escape: keep the backslash and the byte
                    n_count = 2'd2;
                    b0      = cat_pkg::CH_BSLASH;
                    k0      = cat_pkg::K_VAL;
                    b1      = r_in_byte;
                    k1      = cat_pkg::K_VAL;
                    n_phase = PH_QUOTED;
                end
            end
            default: begin
                if (r_in_byte inside {cat_pkg::CH_NUL, cat_pkg::CH_SPACE}) begin
                    n_phase = PH_IDLE;
                end else if (r_in_byte == cat_pkg::CH_EQUAL) begin
                    n_phase = PH_VSTART;
                end else begin
                    n_count = 2'd1;
                    b0      = r_in_byte;
                    k0      = cat_pkg::K_KEY;
                    n_phase = PH_KEY;
                end
            end
        endcase
    end

    always_comb begin
        o_push.valid       = advance && (n_count != 2'd0);
        o_push.two         = n_count == 2'd2;
        o_push.r0.out_byte = b0;
        o_push.r0.out_kind = k0;
        o_push.r0.run_last = n_count == 2'd1;
        o_push.r1.out_byte = b1;
        o_push.r1.out_kind = k1;
        o_push.r1.run_last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_IDLE;
        end else begin
            if (i_cmd.ready) begin
                r_in_valid <= i_cmd.valid;
            end
            if (advance) begin
                r_phase <= n_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_in_byte <= i_cmd.cmd_byte;
        end
    end

endmodule

// ----- src/cat_fifo.sv -----
// Four-entry result queue that takes one or two results per cycle and
// presents one result beat at a time. Depends on cat_pkg and cat_out_if.
module cat_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cat_pkg::t_push  i_push,
    output logic            o_room,
    cat_out_if.source       o_res
);

    cat_pkg::t_result r_mem [4];
    logic [1:0]       r_wr_ptr;
    logic [1:0]       r_rd_ptr;
    logic [2:0]       r_count;

    logic [1:0]       wr_next;
    logic             pop;
    logic [2:0]       push_n;
    cat_pkg::t_result head;

    assign wr_next = r_wr_ptr + 2'd1;
    assign pop     = o_res.valid && o_res.ready;
    assign push_n  = !i_push.valid ? 3'd0 : (i_push.two ? 3'd2 : 3'd1);
    assign o_room  = r_count <= 3'd2;
    assign head    = r_mem[r_rd_ptr];

    assign o_res.valid    = r_count != 3'd0;
    assign o_res.out_byte = head.out_byte;
    assign o_res.out_kind = head.out_kind;
    assign o_res.run_last = head.run_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_n[1:0];
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + push_n - {2'b00, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.r0;
            if (i_push.two) begin
                r_mem[wr_next] <= i_push.r1;
            end
        end
    end

endmodule

// ----- src/cmdline_argument_tokenizer.sv -----
// Top level of the boot command line argument tokenizer.
// Depends on cat_pkg, cat_if, cat_dec and cat_fifo.
//
// Usage:
//   i_cmd carries one command line byte per beat (cmd_byte); a zero byte
//   ends the line and returns the parser to idle.
//   o_res carries result beats: out_byte, out_kind (key char, value char,
//   end with value, end without value, discard) and run_last, which is set
//   on the last result a given input byte produced.
//   A byte is held in the input register, is decoded and written into the
//   result queue, and its results are then presented on o_res in order.
//   Throughput: one byte per cycle while the receiver takes every beat and
//   each byte yields at most one result; an unknown escape inside quotes
//   yields two results, which the result queue presents one beat at a time.
//   Bytes that yield nothing (spaces while idle, '=', opening quote,
//   backslash) still pass at one per cycle while the queue has room.
//   Reset (synchronous, active low) empties the queue and puts the parser
//   in idle, skipping spaces.
//   When the receiver stalls, up to four results are held; the input
//   stays ready while the queue has room for two more results.
module cmdline_argument_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cat_in_if.sink     i_cmd,
    cat_out_if.source  o_res
);

    cat_pkg::t_push push;
    logic           room;

    // decode stage: input register + phase state
    cat_dec u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_room  (room),
        .o_push  (push)
    );

    // result queue: absorbs the two-result escape case and receiver stalls
    cat_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_res   (o_res)
    );

endmodule

// ----- tb/tb_cmdline_argument_tokenizer.sv -----
// Testbench for cmdline_argument_tokenizer: directed byte table plus random command lines.
// Predicts beats by its tokenizer model or hand-written rows; checks o_res beat by beat.
// Depends on cat_pkg, cat_if and the tokenizer RTL.
module tb_cmdline_argument_tokenizer;

    // Parser phases as the predictor tracks them; unused codes fall back to idle.
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_KEY      = 3'd1,
        PH_VSTART   = 3'd2,
        PH_UNQUOTED = 3'd3,
        PH_QUOTED   = 3'd4,
        PH_ESCAPE   = 3'd5
    } t_phase;

    // One row of the directed table. Where typed is set, cnt/rbyte/rkind hold the
    // expected outcome written by hand and go to the scoreboard instead of the
    // predictor's; the predictor still runs on the byte to keep its phase in step.
    typedef struct packed {
        logic [7:0]     cmd;
        logic           typed;
        logic [1:0]     cnt;
        logic [7:0]     rbyte;
        cat_pkg::t_kind rkind;
    } t_row;

    localparam int N_ROWS     = 33;
    localparam int RAND_ITEMS = 1850;
    localparam int DRAIN_CYC  = 20;

    logic i_clk;
    logic i_rst_n;

    cat_in_if  cmd_ch ();
    cat_out_if res_ch ();

    cmdline_argument_tokenizer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    t_phase           parse_phase;           // predictor state
    cat_pkg::t_result pending_results [$];   // result beats still owed by the block
    t_row             dir_rows [N_ROWS];
    int               fed_items;             // bytes accepted by the block
    int               src_idle_pct;
    int               snk_idle_pct;
    int               fail_count;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Known values on every block input from time zero.
    initial begin
        i_rst_n         = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.cmd_byte = 8'h00;
        res_ch.ready    = 1'b0;
    end

    // Receiver: ready redrawn at each falling edge, so stalls land on any cycle.
    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Tokenizer predictor: one byte in, up to two result beats out.
    // Updates parse_phase; returns the number of results.
    function automatic int tokenize_byte(input logic [7:0] c,
                                         output cat_pkg::t_result r0,
                                         output cat_pkg::t_result r1);
        int               n;
        t_phase           ph;
        cat_pkg::t_result rs [2];
        n  = 0;
        ph = parse_phase;
        rs[0] = '0;
        rs[1] = '0;
        case (ph)
            PH_KEY: begin
                if (c == cat_pkg::CH_NUL || c == cat_pkg::CH_SPACE) begin
                    rs[n] = '{8'h00, cat_pkg::K_END_NOVAL, 1'b0}; n++;
                    ph = PH_IDLE;
                end else if (c == cat_pkg::CH_EQUAL) begin
                    ph = PH_VSTART;
                end else begin
                    rs[n] = '{c, cat_pkg::K_KEY, 1'b0}; n++;
                end
            end
            PH_VSTART: begin
                // "key=" followed by space or zero still counts as a value (empty)
                if (c == cat_pkg::CH_NUL || c == cat_pkg::CH_SPACE) begin
                    rs[n] = '{8'h00, cat_pkg::K_END_VAL, 1'b0}; n++;
                    ph = PH_IDLE;
                end else if (c == cat_pkg::CH_QUOTE) begin
                    ph = PH_QUOTED;
                end else begin
                    rs[n] = '{c, cat_pkg::K_VAL, 1'b0}; n++;
                    ph = PH_UNQUOTED;
                end
            end
            PH_UNQUOTED: begin
                // quote, '=' and backslash are plain characters here
                if (c == cat_pkg::CH_NUL || c == cat_pkg::CH_SPACE) begin
                    rs[n] = '{8'h00, cat_pkg::K_END_VAL, 1'b0}; n++;
                    ph = PH_IDLE;
                end else begin
                    rs[n] = '{c, cat_pkg::K_VAL, 1'b0}; n++;
                end
            end
            PH_QUOTED: begin
                if (c == cat_pkg::CH_NUL) begin
                    rs[n] = '{8'h00, cat_pkg::K_DISCARD, 1'b0}; n++;
                    ph = PH_IDLE;
                end else if (c == cat_pkg::CH_QUOTE) begin
                    // closing quote goes straight back to key scanning
                    rs[n] = '{8'h00, cat_pkg::K_END_VAL, 1'b0}; n++;
                    ph = PH_IDLE;
                end else if (c == cat_pkg::CH_BSLASH) begin
                    ph = PH_ESCAPE;
                end else begin
                    rs[n] = '{c, cat_pkg::K_VAL, 1'b0}; n++;
                end
            end
            PH_ESCAPE: begin
                if (c == cat_pkg::CH_NUL) begin
                    rs[n] = '{8'h00, cat_pkg::K_DISCARD, 1'b0}; n++;
                    ph = PH_IDLE;
                end else if (c == cat_pkg::CH_QUOTE || c == cat_pkg::CH_BSLASH) begin
                    rs[n] = '{c, cat_pkg::K_VAL, 1'b0}; n++;
                    ph = PH_QUOTED;
                end else begin
                    // unknown escape keeps both bytes: two beats
                    rs[n] = '{cat_pkg::CH_BSLASH, cat_pkg::K_VAL, 1'b0}; n++;
                    rs[n] = '{c, cat_pkg::K_VAL, 1'b0}; n++;
                    ph = PH_QUOTED;
                end
            end
            default: begin
                if (c == cat_pkg::CH_NUL || c == cat_pkg::CH_SPACE) begin
                    ph = PH_IDLE;
                end else if (c == cat_pkg::CH_EQUAL) begin
                    ph = PH_VSTART;
                end else begin
                    rs[n] = '{c, cat_pkg::K_KEY, 1'b0}; n++;
                    ph = PH_KEY;
                end
            end
        endcase
        if (n > 0) begin
            rs[n-1].run_last = 1'b1;
        end
        parse_phase = ph;
        r0 = rs[0];
        r1 = rs[1];
        return n;
    endfunction

    // Random nonzero byte other than the three excluded ones.
    function automatic logic [7:0] pick_char(input logic [7:0] x0, input logic [7:0] x1,
                                             input logic [7:0] x2);
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        while (c == x0 || c == x1 || c == x2) begin
            c = 8'($urandom_range(1, 255));
        end
        return c;
    endfunction

    // Drive one input beat, wait for it to be taken, then book its results.
    // valid stays high from one beat to the next unless a sender gap is drawn.
    task automatic feed_byte(input logic [7:0] b, input logic typed = 1'b0,
                             input logic [1:0] cnt = 2'd0, input logic [7:0] rbyte = 8'h00,
                             input cat_pkg::t_kind rkind = cat_pkg::K_KEY);
        cat_pkg::t_result r0;
        cat_pkg::t_result r1;
        int               n;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.cmd_byte <= b;
        do @(posedge i_clk); while (!cmd_ch.ready);
        n = tokenize_byte(b, r0, r1);
        if (typed) begin
            if (cnt != 2'd0) pending_results.push_back('{rbyte, rkind, 1'b1});
        end else begin
            if (n > 0) pending_results.push_back(r0);
            if (n > 1) pending_results.push_back(r1);
        end
        fed_items++;
    endtask

    // One command line: mostly well-formed arguments with random content,
    // now and then cut short inside quotes.
    task automatic write_line();
        int n_args;
        int mode;
        int klen;
        int vlen;
        int sel;
        bit cut;
        cut    = 1'b0;
        n_args = $urandom_range(1, 5);
        repeat ($urandom_range(0, 2)) feed_byte(cat_pkg::CH_SPACE);
        for (int a = 0; a < n_args && !cut; a++) begin
            // 0..2 bare key, 3..5 unquoted value, 6..9 quoted value
            mode = $urandom_range(0, 9);
            klen = $urandom_range((mode < 3) ? 1 : 0, 6);
            repeat (klen) begin
                feed_byte(pick_char(cat_pkg::CH_SPACE, cat_pkg::CH_EQUAL, cat_pkg::CH_NUL));
            end
            if (mode >= 3) feed_byte(cat_pkg::CH_EQUAL);
            if (mode >= 3 && mode <= 5) begin
                vlen = $urandom_range(0, 6);
                for (int i = 0; i < vlen; i++) begin
                    // a leading quote would open a quoted value instead
                    if (i == 0) begin
                        feed_byte(pick_char(cat_pkg::CH_SPACE, cat_pkg::CH_QUOTE,
                                            cat_pkg::CH_NUL));
                    end else begin
                        feed_byte(pick_char(cat_pkg::CH_SPACE, cat_pkg::CH_SPACE,
                                            cat_pkg::CH_NUL));
                    end
                end
            end else if (mode >= 6) begin
                feed_byte(cat_pkg::CH_QUOTE);
                vlen = $urandom_range(0, 6);
                repeat (vlen) begin
                    sel = $urandom_range(0, 9);
                    if (sel < 6) begin
                        feed_byte(pick_char(cat_pkg::CH_QUOTE, cat_pkg::CH_BSLASH,
                                            cat_pkg::CH_NUL));
                    end else begin
                        feed_byte(cat_pkg::CH_BSLASH);
                        if (sel == 6)      feed_byte(cat_pkg::CH_QUOTE);
                        else if (sel == 7) feed_byte(cat_pkg::CH_BSLASH);
                        else               feed_byte(pick_char(cat_pkg::CH_QUOTE,
                                                               cat_pkg::CH_BSLASH,
                                                               cat_pkg::CH_NUL));
                    end
                end
                sel = $urandom_range(0, 19);
                if (sel == 0) begin
                    feed_byte(cat_pkg::CH_NUL);         // line ends inside quotes
                    cut = 1'b1;
                end else if (sel == 1) begin
                    feed_byte(cat_pkg::CH_BSLASH);      // dangling backslash at line end
                    feed_byte(cat_pkg::CH_NUL);
                    cut = 1'b1;
                end else begin
                    feed_byte(cat_pkg::CH_QUOTE);
                    // sometimes the next key follows the closing quote directly
                    if ($urandom_range(0, 3) == 0) continue;
                end
            end
            if (!cut && a + 1 < n_args) begin
                repeat ($urandom_range(1, 3)) feed_byte(cat_pkg::CH_SPACE);
            end
        end
        if (!cut) feed_byte(cat_pkg::CH_NUL);
    endtask

    // Scoreboard: every result beat taken at a rising edge against the oldest owed one.
    always @(posedge i_clk) begin
        cat_pkg::t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat byte=%02h kind=%0d last=%b",
                         $time, res_ch.out_byte, res_ch.out_kind, res_ch.run_last);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_ch.out_byte !== want.out_byte || res_ch.out_kind !== want.out_kind ||
                    res_ch.run_last !== want.run_last) begin
                    $display("%0t: expected %02h/%0d/%b, got %02h/%0d/%b (byte/kind/last)",
                             $time, want.out_byte, want.out_kind, want.run_last,
                             res_ch.out_byte, res_ch.out_kind, res_ch.run_last);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random lines in three idle regimes.
    initial begin
        parse_phase  = PH_IDLE;
        fed_items    = 0;
        fail_count   = 0;
        src_idle_pct = 13;
        snk_idle_pct = 60;

        // Directed rows: idle skipping, both kinds of empty value, key ends,
        // byte extremes, every escape, closing quote into a new key,
        // quote/'='/backslash as plain unquoted chars, both discard paths.
        dir_rows = '{
            // space while idle, zero while idle, empty key, empty value by space
            '{cat_pkg::CH_SPACE, 1'b1, 2'd0, 8'h00, cat_pkg::K_KEY},
            '{cat_pkg::CH_NUL, 1'b1, 2'd0, 8'h00, cat_pkg::K_KEY},
            '{cat_pkg::CH_EQUAL, 1'b1, 2'd0, 8'h00, cat_pkg::K_KEY},
            '{cat_pkg::CH_SPACE, 1'b1, 2'd1, 8'h00, cat_pkg::K_END_VAL},
            '{8'hFF, 1'b1, 2'd1, 8'hFF, cat_pkg::K_KEY},
            '{cat_pkg::CH_SPACE, 1'b1, 2'd1, 8'h00, cat_pkg::K_END_NOVAL},
            '{8'h01, 1'b1, 2'd1, 8'h01, cat_pkg::K_KEY},
            '{cat_pkg::CH_EQUAL, 1'b1, 2'd0, 8'h00, cat_pkg::K_KEY},
            // empty value by zero
            '{cat_pkg::CH_NUL, 1'b1, 2'd1, 8'h00, cat_pkg::K_END_VAL},
            '{cat_pkg::CH_EQUAL, 1'b1, 2'd0, 8'h00, cat_pkg::K_KEY},
            // opening quote, escaped quote, escaped backslash
            '{cat_pkg::CH_QUOTE, 1'b1, 2'd0, 8'h00, cat_pkg::K_KEY},
            '{cat_pkg::CH_BSLASH, 1'b1, 2'd0, 8'h00, cat_pkg::K_KEY},
            '{cat_pkg::CH_QUOTE, 1'b1, 2'd1, cat_pkg::CH_QUOTE, cat_pkg::K_VAL},
            '{cat_pkg::CH_BSLASH, 1'b1, 2'd0, 8'h00, cat_pkg::K_KEY},
            '{cat_pkg::CH_BSLASH, 1'b1, 2'd1, cat_pkg::CH_BSLASH, cat_pkg::K_VAL},
            // unknown escape, two beats
            '{cat_pkg::CH_BSLASH, 1'b1, 2'd0, 8'h00, cat_pkg::K_KEY},
            '{8'h80, 1'b0, 2'd0, 8'h00, cat_pkg::K_KEY},
            // closing quote, then a key right after it
            '{cat_pkg::CH_QUOTE, 1'b1, 2'd1, 8'h00, cat_pkg::K_END_VAL},
            '{8'h6B, 1'b0, 2'd0, 8'h00, cat_pkg::K_KEY},
            '{cat_pkg::CH_NUL, 1'b1, 2'd1, 8'h00, cat_pkg::K_END_NOVAL},
            // quote, backslash and '=' as plain chars in an unquoted value
            '{cat_pkg::CH_EQUAL, 1'b1, 2'd0, 8'h00, cat_pkg::K_KEY},
            '{8'h7F, 1'b0, 2'd0, 8'h00, cat_pkg::K_KEY},
            '{cat_pkg::CH_QUOTE, 1'b0, 2'd0, 8'h00, cat_pkg::K_KEY},
            '{cat_pkg::CH_BSLASH, 1'b0, 2'd0, 8'h00, cat_pkg::K_KEY},
            '{cat_pkg::CH_EQUAL, 1'b0, 2'd0, 8'h00, cat_pkg::K_KEY},
            '{cat_pkg::CH_SPACE, 1'b1, 2'd1, 8'h00, cat_pkg::K_END_VAL},
            // zero inside quotes
            '{cat_pkg::CH_EQUAL, 1'b1, 2'd0, 8'h00, cat_pkg::K_KEY},
            '{cat_pkg::CH_QUOTE, 1'b1, 2'd0, 8'h00, cat_pkg::K_KEY},
            '{cat_pkg::CH_NUL, 1'b1, 2'd1, 8'h00, cat_pkg::K_DISCARD},
            // zero after backslash
            '{cat_pkg::CH_EQUAL, 1'b1, 2'd0, 8'h00, cat_pkg::K_KEY},
            '{cat_pkg::CH_QUOTE, 1'b1, 2'd0, 8'h00, cat_pkg::K_KEY},
            '{cat_pkg::CH_BSLASH, 1'b1, 2'd0, 8'h00, cat_pkg::K_KEY},
            '{cat_pkg::CH_NUL, 1'b1, 2'd1, 8'h00, cat_pkg::K_DISCARD}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            feed_byte(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].cnt,
                      dir_rows[i].rbyte, dir_rows[i].rkind);
        end

        fed_items = 0;
        while (fed_items < RAND_ITEMS) begin
            // sender busy / receiver stalling, then swapped, then no idling
            if (fed_items < RAND_ITEMS / 3) begin
                src_idle_pct = 13;
                snk_idle_pct = 60;
            end else if (fed_items < 2 * RAND_ITEMS / 3) begin
                src_idle_pct = 60;
                snk_idle_pct = 13;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            if ($urandom_range(0, 99) < 15) begin
                // noise: arbitrary bytes from whatever phase the parser is in
                repeat ($urandom_range(1, 12)) feed_byte(8'($urandom_range(0, 255)));
            end else begin
                write_line();
            end
        end

        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        snk_idle_pct = 0;

        while (pending_results.size() != 0) @(posedge i_clk);
        // extra cycles so a stray beat after the last owed one is still caught
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #3000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
